// File: sv/affine_tilemap_span_renderer_top_macros.svh
// assertion helpers for the span renderer
`ifndef AFFINE_TILEMAP_SPAN_RENDERER_TOP_MACROS_SVH
`define AFFINE_TILEMAP_SPAN_RENDERER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define ATSR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("span renderer check failed");
// next-cycle implication
`define ATSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("span renderer check failed");
`else
`define ATSR_ASSERT_NOW(lbl, ante, cons)
`define ATSR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/atsr_pkg.sv
package atsr_pkg;

	// request codes
	typedef enum logic [2:0] {
		REQ_LOAD_MAP   = 3'd0,
		REQ_LOAD_TEXEL = 3'd1,
		REQ_LOAD_TRANS = 3'd2,
		REQ_SPAN_START = 3'd3,
		REQ_STEP       = 3'd4
	} req_e;

	// drawing modes
	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_LOW    = 2'd1,
		MODE_SHADOW = 2'd2
	} mode_e;

	// work carried down the pipe
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_PIX   = 2'd1,
		OP_TEXEL = 2'd2,
		OP_TRANS = 2'd3
	} op_e;

	typedef struct packed {
		op_e         op;
		mode_e       mode;
		logic        last;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [7:0]  dest;
		logic [17:0] laddr;
		logic [7:0]  ldata;
		logic        tex_ok;
	} stage_t;

	localparam int MAP_HI      = 31;
	localparam int MAP_LO      = 25;
	localparam int TEXEL_HI    = 24;
	localparam int TEXEL_LO    = 19;
	localparam int MAP_DEPTH   = 16384;
	localparam int TRANS_DEPTH = 512;
	localparam int TILE_TEXELS = 4096;

	localparam logic [7:0] SHADOW_LOW    = 8'd160;
	localparam logic [7:0] SHADOW_HIGH   = 8'd192;
	localparam logic [7:0] SHADOW_COLOUR = 8'd185;

	// output queue entries
	localparam int OUT_DEPTH = 8;

endpackage

// File: sv/affine_tilemap_span_renderer_top.sv
// Affine tilemap span renderer.
// Input channel (in_valid / in_stall) takes one request per cycle unless stalled:
// map, texel and translation loads, a span start, or a pixel step. Output channel
// (out_valid / out_stall) delivers pixel and span_last. cfg_write_en with
// cfg_write_data sets use_translation; write it only while the block is idle.
// A pixel step is carried through the stage registers st_s1, st_s2 and st_s3
// and then written into the output queue. The step walks three synchronous
// memories in turn: map store at stage 0, texel store at stage 1, translation
// store at stage 2; each load is written at the stage where its store is read,
// so program order holds. Throughput is one request per cycle when not stalled;
// a low-resolution step yields two results, so a run of them is paced by the
// one-result-per-cycle output port.
// Results go into an 8-entry output queue; in_stall rises when fewer than two
// queue entries are left unreserved, so a stalled receiver never loses data.
// Reset clears position, step, count, mode, pipe and queue; the stores hold
// no reset value and need no clearing pass.
`include "affine_tilemap_span_renderer_top_macros.svh"

module affine_tilemap_span_renderer_top #(
	parameter int TILE_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [17:0] load_address,
	input  logic [7:0]  load_data,
	input  logic [31:0] start_x,
	input  logic [31:0] start_y,
	input  logic [31:0] step_x,
	input  logic [31:0] step_y,
	input  logic [11:0] span_width,
	input  logic [1:0]  draw_mode,
	input  logic [7:0]  dest_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pixel,
	output logic        span_last
);

	import atsr_pkg::*;

	localparam int MAP_W = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
	localparam int TXW   = $clog2(TILE_COUNT * TILE_TEXELS);
	localparam int PW    = $clog2(OUT_DEPTH);
	localparam int RW    = $clog2(OUT_DEPTH + 1);

	logic        use_trans_q;
	logic [31:0] pos_x_q, pos_y_q, delta_x_q, delta_y_q;
	logic [11:0] steps_q;
	mode_e       mode_q;

	logic        acc, pix;
	stage_t      st_s1, st_s2, st_s3;
	logic [7:0]  tex_s3;
	logic        hit_s3;

	logic [RW-1:0] res_q;
	logic [PW-1:0] wp_q, rp_q;
	logic [RW-1:0] cnt_q;
	logic [7:0]    out_pix_q  [OUT_DEPTH];
	logic          out_last_q [OUT_DEPTH];

	// tile numbers are stored modulo the tile count
	logic [MAP_W-1:0] tile_mod [256];
	for (genvar i = 0; i < 256; i++) begin : g_mod
		assign tile_mod[i] = MAP_W'(i % TILE_COUNT);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_trans_q <= 1'b0;
		end else if (cfg_write_en) begin
			use_trans_q <= cfg_write_data;
		end
	end

	// admission: keep room for the two results a low-resolution step may reserve
	assign in_stall = res_q > RW'(OUT_DEPTH - 2);
	assign acc      = in_valid && !in_stall;
	assign pix      = acc && (req_type == REQ_STEP) && (steps_q != 12'd0);

	// stage 0: span state and map read
	logic [MAP_W-1:0] map_rdata;
	atsr_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map (
		.clk   (clk),
		.we    (acc && (req_type == REQ_LOAD_MAP)),
		.waddr (load_address[13:0]),
		.wdata (tile_mod[load_data]),
		.raddr ({pos_y_q[MAP_HI:MAP_LO], pos_x_q[MAP_HI:MAP_LO]}),
		.rdata (map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			delta_x_q <= '0;
			delta_y_q <= '0;
			steps_q   <= '0;
			mode_q    <= MODE_NORMAL;
		end else if (acc && (req_type == REQ_SPAN_START)) begin
			if (draw_mode == MODE_LOW) begin
				pos_x_q   <= start_x + step_x;
				pos_y_q   <= start_y + step_y;
				delta_x_q <= {step_x[30:0], 1'b0};
				delta_y_q <= {step_y[30:0], 1'b0};
				steps_q   <= {1'b0, span_width[11:1]};
				mode_q    <= MODE_LOW;
			end else begin
				pos_x_q   <= start_x;
				pos_y_q   <= start_y;
				delta_x_q <= step_x;
				delta_y_q <= step_y;
				steps_q   <= span_width;
				mode_q    <= (draw_mode == MODE_SHADOW) ? MODE_SHADOW : MODE_NORMAL;
			end
		end else if (pix) begin
			pos_x_q <= pos_x_q + delta_x_q;
			pos_y_q <= pos_y_q + delta_y_q;
			steps_q <= steps_q - 12'd1;
		end
	end

	// stage 0 to 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else begin
			if (pix) begin
				st_s1.op <= OP_PIX;
			end else if (acc && (req_type == REQ_LOAD_TEXEL)) begin
				st_s1.op <= OP_TEXEL;
			end else if (acc && (req_type == REQ_LOAD_TRANS)) begin
				st_s1.op <= OP_TRANS;
			end else begin
				st_s1.op <= OP_NONE;
			end
			st_s1.mode   <= mode_q;
			st_s1.last   <= steps_q == 12'd1;
			st_s1.row    <= pos_y_q[TEXEL_HI:TEXEL_LO];
			st_s1.col    <= pos_x_q[TEXEL_HI:TEXEL_LO];
			st_s1.dest   <= dest_pixel;
			st_s1.laddr  <= load_address;
			st_s1.ldata  <= load_data;
			st_s1.tex_ok <= {3'b000, load_address[17:12]} < 9'(TILE_COUNT);
		end
	end

	// stage 1: tile lookup and texel read
	logic [MAP_W-1:0] tile_s1;
	logic [7:0]       texel_rdata;
	assign tile_s1 = ({{(32 - MAP_W){1'b0}}, map_rdata} >= 32'(TILE_COUNT)) ? '0 : map_rdata;

	atsr_ram #(.WIDTH(8), .DEPTH(TILE_COUNT * TILE_TEXELS)) u_texel (
		.clk   (clk),
		.we    ((st_s1.op == OP_TEXEL) && st_s1.tex_ok),
		.waddr (TXW'(st_s1.laddr)),
		.wdata (st_s1.ldata),
		.raddr (TXW'({tile_s1, st_s1.row, st_s1.col})),
		.rdata (texel_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s2 <= '0;
		end else begin
			st_s2 <= st_s1;
		end
	end

	// stage 2: shadow test and translation read
	logic [8:0] trans_raddr;
	logic [7:0] trans_rdata;
	assign trans_raddr = (st_s2.mode == MODE_SHADOW) ? {1'b1, st_s2.dest} : {1'b0, texel_rdata};

	atsr_ram #(.WIDTH(8), .DEPTH(TRANS_DEPTH)) u_trans (
		.clk   (clk),
		.we    (st_s2.op == OP_TRANS),
		.waddr (st_s2.laddr[8:0]),
		.wdata (st_s2.ldata),
		.raddr (trans_raddr),
		.rdata (trans_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s3 <= '0;
		end else begin
			st_s3 <= st_s2;
		end
	end

	always_ff @(posedge clk) begin
		tex_s3 <= texel_rdata;
		hit_s3 <= (texel_rdata >= SHADOW_LOW) && (texel_rdata < SHADOW_HIGH);
	end

	// stage 3: final colour
	logic [7:0] colour_s3;
	logic       push, push2, pop;
	always_comb begin
		unique case (st_s3.mode)
			MODE_SHADOW: colour_s3 = hit_s3 ? SHADOW_COLOUR : trans_rdata;
			default:     colour_s3 = use_trans_q ? trans_rdata : tex_s3;
		endcase
	end

	assign push  = st_s3.op == OP_PIX;
	assign push2 = push && (st_s3.mode == MODE_LOW);
	assign pop   = out_valid && !out_stall;

	// output queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			out_pix_q[wp_q]  <= colour_s3;
			out_last_q[wp_q] <= st_s3.last && !push2;
		end
		if (push2) begin
			out_pix_q[wp_q + PW'(1)]  <= colour_s3;
			out_last_q[wp_q + PW'(1)] <= st_s3.last;
		end
	end

	// queue pointers, fill count and reservations
	logic [RW-1:0] n_push, n_resv;
	assign n_push = push2 ? RW'(2) : (push ? RW'(1) : RW'(0));
	assign n_resv = pix ? ((mode_q == MODE_LOW) ? RW'(2) : RW'(1)) : RW'(0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
			res_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(n_push);
			rp_q  <= rp_q + PW'(pop);
			cnt_q <= cnt_q + n_push - RW'(pop);
			res_q <= res_q + n_resv - RW'(pop);
		end
	end

	assign out_valid = cnt_q != '0;
	assign pixel     = out_pix_q[rp_q];
	assign span_last = out_last_q[rp_q];

	// checks
	`ATSR_ASSERT_NOW(a_fill_within_resv, 1'b1, cnt_q <= res_q)
	`ATSR_ASSERT_NOW(a_resv_bound, 1'b1, res_q <= RW'(OUT_DEPTH))
	`ATSR_ASSERT_NEXT(a_step_enters_pipe, pix, st_s1.op == OP_PIX)
	`ATSR_ASSERT_NOW(a_stall_when_full, res_q > RW'(OUT_DEPTH - 2), !pix)

endmodule

// File: sv/atsr_ram.sv
module atsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
